### rtl/core/lpr_pkg.sv
//----------------------------------------------------------------------------
// Line pixel rasterizer package
// Coordinate and error-term types, item kinds and the payload structs that
// move between the front end, the command queue and the pixel engine.
//----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned COORD_BITS = 12;
  // Error term and its increments span twice the largest span, plus sign
  localparam int unsigned ERR_W      = COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic signed [ERR_W-1:0]      err_t;

  localparam logic   KIND_LOAD = 1'b0;
  localparam logic   KIND_STEP = 1'b1;
  localparam coord_t COORD_ONE = coord_t'(1);

  typedef struct packed {
    logic   kind;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last;
  } out_item_t;

  // Classified command: the item plus span signs and magnitudes
  typedef struct packed {
    in_item_t item;
    logic     dx_neg;
    logic     dy_neg;
    logic     dx_zero;
    logic     dy_zero;
    mag_t     adx;
    mag_t     ady;
  } cmd_t;

endpackage

### rtl/core/lpr_fifo.sv
//----------------------------------------------------------------------------
// Two-entry word queue
// Small decoupling queue; push and pop may both happen in one cycle.
//----------------------------------------------------------------------------
module lpr_fifo #(
  parameter type entry_t = logic
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   empty_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/lpr_front.sv
//----------------------------------------------------------------------------
// Line pixel rasterizer front end
// Classifies an incoming word: endpoint spans, their signs and magnitudes.
//----------------------------------------------------------------------------
module lpr_front (
  input  lpr_pkg::in_item_t item_i,
  output lpr_pkg::cmd_t     cmd_o
);

  import lpr_pkg::*;

  logic signed [COORD_BITS:0] dx, dy;
  logic signed [COORD_BITS:0] adx_w, ady_w;

  always_comb begin
    dx    = {item_i.x_end[COORD_BITS-1], item_i.x_end}
          - {item_i.x_start[COORD_BITS-1], item_i.x_start};
    dy    = {item_i.y_end[COORD_BITS-1], item_i.y_end}
          - {item_i.y_start[COORD_BITS-1], item_i.y_start};
    adx_w = dx[COORD_BITS] ? -dx : dx;
    ady_w = dy[COORD_BITS] ? -dy : dy;

    cmd_o.item    = item_i;
    cmd_o.dx_neg  = dx[COORD_BITS];
    cmd_o.dy_neg  = dy[COORD_BITS];
    cmd_o.dx_zero = (dx == '0);
    cmd_o.dy_zero = (dy == '0);
    // a span never exceeds the coordinate range, so the top bit is spare
    cmd_o.adx     = adx_w[COORD_BITS-1:0];
    cmd_o.ady     = ady_w[COORD_BITS-1:0];
  end

endmodule

### rtl/core/lpr_back.sv
//----------------------------------------------------------------------------
// Line pixel rasterizer pixel engine
// Holds the walk state and turns each command into at most one pixel word.
//----------------------------------------------------------------------------
module lpr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpr_pkg::cmd_t      cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output lpr_pkg::out_item_t res_o
);

  import lpr_pkg::*;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeVert,
    ModeHorz,
    ModeDiag,
    ModeXMaj,
    ModeYMaj
  } mode_e;

  mode_e  mode_q, mode_d;
  coord_t cur_x_q, cur_x_d;
  coord_t cur_y_q, cur_y_d;
  coord_t end_major_q, end_major_d;
  err_t   err_q, err_d;
  err_t   add_hold_q, add_hold_d;
  err_t   add_move_q, add_move_d;
  logic   dir_x_neg_q, dir_x_neg_d;
  logic   dir_y_neg_q, dir_y_neg_d;

  logic   go;
  logic   emit;
  logic   last;
  err_t   adx_e, ady_e, two_adx, two_ady;
  coord_t xa, ya, xb, yb;

  always_comb begin
    go          = ~cmd_empty_i & ~res_full_i;
    emit        = 1'b0;
    last        = 1'b0;
    mode_d      = mode_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    end_major_d = end_major_q;
    err_d       = err_q;
    add_hold_d  = add_hold_q;
    add_move_d  = add_move_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;

    xa      = cmd_i.item.x_start;
    ya      = cmd_i.item.y_start;
    xb      = cmd_i.item.x_end;
    yb      = cmd_i.item.y_end;
    adx_e   = err_t'({2'b00, cmd_i.adx});
    ady_e   = err_t'({2'b00, cmd_i.ady});
    two_adx = err_t'({1'b0, cmd_i.adx, 1'b0});
    two_ady = err_t'({1'b0, cmd_i.ady, 1'b0});

    if (go) begin
      if (cmd_i.item.kind == KIND_LOAD) begin
        emit        = 1'b1;
        dir_x_neg_d = 1'b0;
        dir_y_neg_d = 1'b0;
        err_d       = '0;
        add_hold_d  = '0;
        add_move_d  = '0;
        if (cmd_i.dx_zero) begin
          // vertical, walk from the lower y; a single point ends at once
          mode_d      = ModeVert;
          cur_x_d     = xa;
          cur_y_d     = cmd_i.dy_neg ? yb : ya;
          end_major_d = cmd_i.dy_neg ? ya : yb;
          last        = cmd_i.dy_zero;
        end else if (cmd_i.dy_zero) begin
          mode_d      = ModeHorz;
          cur_y_d     = ya;
          cur_x_d     = cmd_i.dx_neg ? xb : xa;
          end_major_d = cmd_i.dx_neg ? xa : xb;
        end else if (cmd_i.adx == cmd_i.ady) begin
          mode_d      = ModeDiag;
          cur_x_d     = xa;
          cur_y_d     = ya;
          dir_x_neg_d = cmd_i.dx_neg;
          dir_y_neg_d = cmd_i.dy_neg;
          end_major_d = xb;
        end else if (cmd_i.adx > cmd_i.ady) begin
          mode_d      = ModeXMaj;
          err_d       = two_ady - adx_e;
          add_hold_d  = two_ady;
          add_move_d  = two_ady - two_adx;
          dir_y_neg_d = cmd_i.dx_neg ^ cmd_i.dy_neg;
          cur_x_d     = cmd_i.dx_neg ? xb : xa;
          cur_y_d     = cmd_i.dx_neg ? yb : ya;
          end_major_d = cmd_i.dx_neg ? xa : xb;
        end else begin
          mode_d      = ModeYMaj;
          err_d       = two_adx - ady_e;
          add_hold_d  = two_adx;
          add_move_d  = two_adx - two_ady;
          dir_x_neg_d = cmd_i.dx_neg ^ cmd_i.dy_neg;
          cur_x_d     = cmd_i.dy_neg ? xb : xa;
          cur_y_d     = cmd_i.dy_neg ? yb : ya;
          end_major_d = cmd_i.dy_neg ? ya : yb;
        end
      end else begin
        unique case (mode_q)
          ModeVert: begin
            emit    = 1'b1;
            cur_y_d = cur_y_q + COORD_ONE;
            last    = (cur_y_d == end_major_q);
          end
          ModeHorz: begin
            emit    = 1'b1;
            cur_x_d = cur_x_q + COORD_ONE;
            last    = (cur_x_d == end_major_q);
          end
          ModeDiag: begin
            emit    = 1'b1;
            cur_x_d = dir_x_neg_q ? cur_x_q - COORD_ONE : cur_x_q + COORD_ONE;
            cur_y_d = dir_y_neg_q ? cur_y_q - COORD_ONE : cur_y_q + COORD_ONE;
            last    = (cur_x_d == end_major_q);
          end
          ModeXMaj: begin
            emit    = 1'b1;
            cur_x_d = cur_x_q + COORD_ONE;
            if (err_q[ERR_W-1]) begin
              err_d = err_q + add_hold_q;
            end else begin
              cur_y_d = dir_y_neg_q ? cur_y_q - COORD_ONE : cur_y_q + COORD_ONE;
              err_d   = err_q + add_move_q;
            end
            last = (cur_x_d == end_major_q);
          end
          ModeYMaj: begin
            emit    = 1'b1;
            cur_y_d = cur_y_q + COORD_ONE;
            if (err_q[ERR_W-1]) begin
              err_d = err_q + add_hold_q;
            end else begin
              cur_x_d = dir_x_neg_q ? cur_x_q - COORD_ONE : cur_x_q + COORD_ONE;
              err_d   = err_q + add_move_q;
            end
            last = (cur_y_d == end_major_q);
          end
          default: begin
            // idle: drop the advance
            mode_d = ModeIdle;
          end
        endcase
      end
    end

    if (emit && last) begin
      mode_d = ModeIdle;
    end

    cmd_pop_o     = go;
    res_push_o    = go & emit;
    res_o.pixel_x = cur_x_d;
    res_o.pixel_y = cur_y_d;
    res_o.last    = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      end_major_q <= '0;
      err_q       <= '0;
      add_hold_q  <= '0;
      add_move_q  <= '0;
      dir_x_neg_q <= 1'b0;
      dir_y_neg_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      end_major_q <= end_major_d;
      err_q       <= err_d;
      add_hold_q  <= add_hold_d;
      add_move_q  <= add_move_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
    end
  end

endmodule

### rtl/core/line_pixel_rasterizer_unit.sv
// Bresenham line rasterizer. A load word (kind 0) takes two endpoints and
// yields the first pixel; each advance word (kind 1) yields the next pixel,
// with last set on the final one, and nothing once the line is done. A load
// abandons any line in progress. Vertical lines run from low to high y,
// horizontal ones from low to high x, exact diagonals from the first
// endpoint; all others walk the major axis upwards. One word is taken per
// cycle while the command queue has room; the engine does one error-term add
// and compare per word and waits while the result queue is full. Two-entry
// queues sit between the front end and the engine and at the output.
//----------------------------------------------------------------------------
// Line pixel rasterizer top level
// Front end classifier, command queue, pixel engine and result queue.
//----------------------------------------------------------------------------
module line_pixel_rasterizer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  lpr_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output lpr_pkg::out_item_t result_o
);

  import lpr_pkg::*;

  cmd_t      cmd_in, cmd_head;
  logic      cmd_empty, cmd_pop;
  logic      res_full, res_push;
  out_item_t res_word;

  lpr_front u_front (
    .item_i (item_i),
    .cmd_o  (cmd_in)
  );

  lpr_fifo #(
    .entry_t (cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  lpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_word)
  );

  lpr_fifo #(
    .entry_t (out_item_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

  // engine never takes from an empty command queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("engine popped an empty command queue");

  // engine never overruns the result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("engine pushed into a full result queue");

  // a pixel only comes from a consumed command
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> cmd_pop)
    else $error("pixel produced without a command");

endmodule

### tb/sv/tb_line_pixel_rasterizer_unit.sv
//----------------------------------------------------------------------------
// Line pixel rasterizer testbench
// Drives load and advance words through the input queue interface, works out
// every pixel the block should yield with a cycle-free line walker of its
// own, and checks each popped pixel against the oldest one still awaited.
// Runs a directed set of lines, then random lines under four idling phases,
// with one long receiver hold-off to back the block up.
//----------------------------------------------------------------------------
module tb_line_pixel_rasterizer_unit;

  import lpr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    WALK_IDLE, WALK_VERT, WALK_HORZ, WALK_DIAG, WALK_XMAJ, WALK_YMAJ
  } walk_e;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  item_i;
  logic      empty;
  logic      pop;
  out_item_t result_o;

  // percent of cycles on which each side idles, indexed by phase
  int unsigned send_idle_pct [4] = '{0, 84, 0, 29};
  int unsigned recv_stall_pct[4] = '{0, 0, 84, 29};

  phase_e    phase = PH_FREE;
  in_item_t  word_q[$];
  out_item_t pixel_q[$];
  out_item_t px_want;
  int        taken_cnt = 0;
  int        fail_cnt = 0;
  int        cycle_cnt;
  int        hold_left;
  bit        hold_done;

  // line walker state
  walk_e  walk;
  coord_t at_x, at_y, stop_major;
  int     err_acc, err_hold, err_move;
  bit     x_back, y_back;

  line_pixel_rasterizer_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic out_item_t put_pixel(bit fin);
    out_item_t px;
    px.pixel_x = at_x;
    px.pixel_y = at_y;
    px.last    = fin;
    if (fin) walk = WALK_IDLE;
    return px;
  endfunction

  // Walk one word; returns 1 when it yields a pixel
  function automatic bit trace_pixel(input in_item_t w, output out_item_t px);
    int dx, dy, adx, ady;
    bit same_sign;
    px = '0;
    if (w.kind == KIND_LOAD) begin
      dx = int'(w.x_end) - int'(w.x_start);
      dy = int'(w.y_end) - int'(w.y_start);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      same_sign = (dx > 0) == (dy > 0);
      x_back = 1'b0;
      y_back = 1'b0;
      err_acc = 0;
      err_hold = 0;
      err_move = 0;
      if (dx == 0) begin
        walk = WALK_VERT;
        at_x = w.x_start;
        at_y = (w.y_start < w.y_end) ? w.y_start : w.y_end;
        stop_major = (w.y_start < w.y_end) ? w.y_end : w.y_start;
        px = put_pixel(at_y == stop_major);
      end else if (dy == 0) begin
        walk = WALK_HORZ;
        at_y = w.y_start;
        at_x = (w.x_start < w.x_end) ? w.x_start : w.x_end;
        stop_major = (w.x_start < w.x_end) ? w.x_end : w.x_start;
        px = put_pixel(1'b0);
      end else if (adx == ady) begin
        walk = WALK_DIAG;
        at_x = w.x_start;
        at_y = w.y_start;
        x_back = dx < 0;
        y_back = dy < 0;
        stop_major = w.x_end;
        px = put_pixel(1'b0);
      end else begin
        if (adx > ady) begin
          walk = WALK_XMAJ;
          err_acc = 2 * ady - adx;
          err_hold = 2 * ady;
          err_move = 2 * (ady - adx);
          y_back = !same_sign;
        end else begin
          walk = WALK_YMAJ;
          err_acc = 2 * adx - ady;
          err_hold = 2 * adx;
          err_move = 2 * (adx - ady);
          x_back = !same_sign;
        end
        // start from the end with the smaller major coordinate
        if ((adx > ady) ? (w.x_start > w.x_end) : (w.y_start > w.y_end)) begin
          at_x = w.x_end;
          at_y = w.y_end;
          stop_major = (adx > ady) ? w.x_start : w.y_start;
        end else begin
          at_x = w.x_start;
          at_y = w.y_start;
          stop_major = (adx > ady) ? w.x_end : w.y_end;
        end
        px = put_pixel(1'b0);
      end
      return 1'b1;
    end
    case (walk)
      WALK_VERT: begin
        at_y = at_y + COORD_ONE;
        px = put_pixel(at_y == stop_major);
      end
      WALK_HORZ: begin
        at_x = at_x + COORD_ONE;
        px = put_pixel(at_x == stop_major);
      end
      WALK_DIAG: begin
        at_x = x_back ? at_x - COORD_ONE : at_x + COORD_ONE;
        at_y = y_back ? at_y - COORD_ONE : at_y + COORD_ONE;
        px = put_pixel(at_x == stop_major);
      end
      WALK_XMAJ: begin
        at_x = at_x + COORD_ONE;
        if (err_acc < 0) begin
          err_acc += err_hold;
        end else begin
          at_y = y_back ? at_y - COORD_ONE : at_y + COORD_ONE;
          err_acc += err_move;
        end
        px = put_pixel(at_x == stop_major);
      end
      WALK_YMAJ: begin
        at_y = at_y + COORD_ONE;
        if (err_acc < 0) begin
          err_acc += err_hold;
        end else begin
          at_x = x_back ? at_x - COORD_ONE : at_x + COORD_ONE;
          err_acc += err_move;
        end
        px = put_pixel(at_y == stop_major);
      end
      default: begin
        walk = WALK_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic note_fail(string msg);
    if (fail_cnt < 10) $display("ERROR: %s", msg);
    fail_cnt++;
  endtask

  // Advance word; endpoint fields are don't-care, so fill them with noise
  task automatic queue_step();
    in_item_t w;
    w.kind    = KIND_STEP;
    w.x_start = coord_t'($urandom());
    w.y_start = coord_t'($urandom());
    w.x_end   = coord_t'($urandom());
    w.y_end   = coord_t'($urandom());
    word_q.push_back(w);
  endtask

  task automatic queue_line(int xa, int ya, int xb, int yb, int n_adv);
    in_item_t w;
    w.kind    = KIND_LOAD;
    w.x_start = coord_t'(xa);
    w.y_start = coord_t'(ya);
    w.x_end   = coord_t'(xb);
    w.y_end   = coord_t'(yb);
    word_q.push_back(w);
    repeat (n_adv) queue_step();
  endtask

  // Far endpoint a + d, reflected or clamped back into the coordinate range
  function automatic int fit_end(int a, int d);
    int b;
    b = a + d;
    if (b > 2047 || b < -2048) b = a - d;
    if (b > 2047) b = 2047;
    if (b < -2048) b = -2048;
    return b;
  endfunction

  task automatic queue_random(int n_words);
    int n, sel, dx, dy, xa, ya, xb, yb, len, n_adv;
    in_item_t w;
    n = 0;
    while (n < n_words) begin
      if (roll(12)) begin
        // noise: any kind, any fields
        w.kind    = 1'($urandom_range(1));
        w.x_start = coord_t'($urandom());
        w.y_start = coord_t'($urandom());
        w.x_end   = coord_t'($urandom());
        w.y_end   = coord_t'($urandom());
        word_q.push_back(w);
        n++;
        continue;
      end
      sel = $urandom_range(99);
      if (sel < 55) begin
        dx = int'($urandom_range(24)) - 12;
        dy = int'($urandom_range(24)) - 12;
      end else if (sel < 70) begin
        dx = int'($urandom_range(30)) - 15;
        dy = 0;
        if (roll(50)) begin
          dy = dx;
          dx = 0;
        end
      end else if (sel < 85) begin
        dx = int'($urandom_range(1, 15));
        dy = roll(50) ? -dx : dx;
        if (roll(50)) dx = -dx;
      end else begin
        dx = int'($urandom_range(8190)) - 4095;
        dy = int'($urandom_range(8190)) - 4095;
      end
      xa = int'(coord_t'($urandom()));
      ya = int'(coord_t'($urandom()));
      xb = fit_end(xa, dx);
      yb = fit_end(ya, dy);
      dx = (xb > xa) ? xb - xa : xa - xb;
      dy = (yb > ya) ? yb - ya : ya - yb;
      len = (dx > dy) ? dx : dy;
      if (len > 40) n_adv = $urandom_range(30);
      else if (roll(80)) n_adv = len + $urandom_range(2);
      else n_adv = $urandom_range(len);
      queue_line(xa, ya, xb, yb, n_adv);
      n += 1 + n_adv;
    end
  endtask

  task automatic drain();
    while (word_q.size() != 0 || pixel_q.size() != 0) @(posedge clk_i);
  endtask

  // Drive on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (word_q.size() != 0 && !roll(send_idle_pct[phase])) begin
        push   <= 1'b1;
        item_i <= word_q[0];
      end else begin
        push <= 1'b0;
      end
      pop <= (hold_left == 0) && !roll(recv_stall_pct[phase]);
    end
  end

  // Hold the output off once for a long stretch so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && phase == PH_FREE && taken_cnt >= 40) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end
  end

  // Sample on the rising edge
  always @(posedge clk_i) begin
    if (push && !full) begin
      if (trace_pixel(item_i, px_want)) pixel_q.push_back(px_want);
      void'(word_q.pop_front());
      taken_cnt <= taken_cnt + 1;
    end
    if (pop && !empty) begin
      if (pixel_q.size() == 0) begin
        note_fail($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                            result_o.pixel_x, result_o.pixel_y, result_o.last));
      end else begin
        px_want = pixel_q.pop_front();
        if (result_o.pixel_x !== px_want.pixel_x || result_o.pixel_y !== px_want.pixel_y ||
            result_o.last !== px_want.last)
          note_fail($sformatf("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                              px_want.pixel_x, px_want.pixel_y, px_want.last,
                              result_o.pixel_x, result_o.pixel_y, result_o.last));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** line_pixel_rasterizer_unit: FAILED **");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    push   = 1'b0;
    pop    = 1'b0;
    item_i = '0;
    walk   = WALK_IDLE;
    at_x   = '0;
    at_y   = '0;
    stop_major = '0;
    err_acc = 0;
    err_hold = 0;
    err_move = 0;
    x_back = 1'b0;
    y_back = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    phase = PH_FREE;
    queue_step();                                // advance with no line loaded
    queue_line(2047, -2048, 2047, -2048, 1);     // single point, then idle advance
    queue_line(5, 1, 5, -1, 2);                  // vertical, given top down
    queue_line(1, -7, -1, -7, 2);                // horizontal, given right to left
    queue_line(0, 0, -2, 2, 2);                  // diagonal up and to the left
    queue_line(2, 0, -1, -1, 3);                 // x-major, reversed
    queue_line(0, 0, 1, -3, 3);                  // y-major, opposite signs
    // full-range lines, each abandoned by the next load
    queue_line(-2048, -2048, 2047, 2047, 1);
    queue_line(-2048, 2047, -2048, -2048, 1);
    queue_line(-2048, 0, 2047, 5, 1);
    queue_line(0, 2047, 3, -2048, 1);
    queue_random(220);
    drain();

    phase = PH_SEND_IDLE;
    queue_random(240);
    drain();

    phase = PH_RECV_STALL;
    queue_random(240);
    drain();

    phase = PH_BOTH;
    queue_random(240);
    drain();

    repeat (10) @(posedge clk_i);
    if (pixel_q.size() != 0) note_fail($sformatf("%0d pixels never arrived", pixel_q.size()));
    if (fail_cnt == 0) begin
      $display("** line_pixel_rasterizer_unit: PASSED **");
    end else begin
      $display("** line_pixel_rasterizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
